>>> rtl/strmm_pkg.sv
package strmm_pkg;

  // fixed field widths of the channels
  localparam int IDX_W      = 10;
  localparam int LEN_W      = IDX_W + 1;
  localparam int LOG_W      = 4;
  localparam int ANS_W      = 32;
  localparam int CFG_DATA_W = 11;

  localparam int MAX_ENTRIES_DEF = 1024;
  localparam int LEVELS_DEF      = 11;
  localparam int VALUE_BITS_DEF  = 32;

  typedef enum logic [1:0] {
    OP_WRITE = 2'd0,
    OP_BUILD = 2'd1,
    OP_QUERY = 2'd2,
    OP_NONE  = 2'd3
  } op_t;

  typedef enum logic [0:0] {
    REG_SELECT_MAX  = 1'b0,
    REG_ENTRY_COUNT = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_QUERY,
    ST_BUILD,
    ST_GAP
  } state_t;

  // query decode handed from the address unit to the controller
  typedef struct packed {
    logic             err;
    logic [LOG_W-1:0] lvl;
    logic [IDX_W-1:0] second;
  } qry_t;

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

>>> rtl/strmm_if.sv
interface strmm_in_if
  import strmm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  op_t                     opcode;
  logic [IDX_W-1:0]        element_index;
  logic signed [ANS_W-1:0] element_value;
  logic [IDX_W-1:0]        left_index;
  logic [IDX_W-1:0]        right_index;

  modport source (output valid, opcode, element_index, element_value, left_index,
                  right_index, input ready);
  modport sink (input valid, opcode, element_index, element_value, left_index,
                right_index, output ready);
endinterface

interface strmm_out_if
  import strmm_pkg::*;
();
  logic                    valid;
  logic                    ready;
  logic signed [ANS_W-1:0] answer;
  logic                    status;

  modport source (output valid, answer, status, input ready);
  modport sink (input valid, answer, status, output ready);
endinterface

>>> rtl/strmm_ram.sv
module strmm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

>>> rtl/strmm_qaddr.sv
module strmm_qaddr
  import strmm_pkg::*;
#(
  parameter int LEVELS = LEVELS_DEF,
  parameter int NW     = 12
) (
  input  logic [IDX_W-1:0] left_index,
  input  logic [IDX_W-1:0] right_index,
  input  logic [NW-1:0]    act_cnt,
  output qry_t             q
);

  logic [LEN_W-1:0] len;
  logic [LOG_W-1:0] k;
  logic             order_bad;
  logic             bound_bad;

  assign len = {1'b0, right_index} - {1'b0, left_index} + LEN_W'(1);

  // floor log2 of the range length: highest set bit wins
  always_comb begin
    k = '0;
    for (int b = 0; b < LEN_W; b++) begin
      if (len[b]) begin
        k = LOG_W'(b);
      end
    end
  end

  assign order_bad = left_index > right_index;
  assign bound_bad = NW'(right_index) >= act_cnt;

  assign q.err    = order_bad || bound_bad || (int'(k) >= LEVELS);
  assign q.lvl    = k;
  assign q.second = right_index - IDX_W'((LEN_W'(1) << k) - LEN_W'(1));

endmodule

>>> rtl/sparse_table_range_min_max_core.sv
// Channel   Dir  Handshake        Payload
// in_if     in   valid / ready    opcode, element_index, element_value, left/right_index
// out_if    out  valid / ready    answer, status
// cfg_*     in   cfg_we           cfg_index, cfg_wdata (no read-back)
//
// Write and unused opcode: result loaded into the output register on accept.
// Query: accept, then ST_QUERY on the registered read of the two-port level
// table. Build: a step per entry of every level it fills, a gap state per level
// for its last write to land, the accept and a final level check; input is held
// off throughout. A waiting result in the output register holds off input until
// it is taken. Sync reset clears control only; the level table is never cleared.
module sparse_table_range_min_max_core
  import strmm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF,
  parameter int LEVELS      = LEVELS_DEF,
  parameter int VALUE_BITS  = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  strmm_in_if.sink              in_if,
  strmm_out_if.source           out_if,
  input  logic                  cfg_we,
  input  reg_idx_t              cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IW    = $clog2(MAX_ENTRIES);
  localparam int LW    = (LEVELS > 1) ? $clog2(LEVELS) : 1;
  localparam int LCW   = $clog2(LEVELS + 1);
  localparam int NW    = max_int(max_int(CFG_DATA_W, $clog2(MAX_ENTRIES + 1)), LEVELS) + 1;
  localparam int AW    = LW + IW;
  localparam int DEPTH = LEVELS * (2 ** IW);

  state_t state_r, state_nxt;

  logic                    sel_max_r;
  logic [CFG_DATA_W-1:0]   ent_cnt_r;
  logic                    out_valid_r, out_valid_nxt;
  logic signed [ANS_W-1:0] out_answer_r, out_answer_nxt;
  logic                    out_status_r, out_status_nxt;
  logic                    q_err_r, q_err_nxt;
  logic [LCW-1:0]          bld_lvl_r, bld_lvl_nxt;
  logic [IW-1:0]           bld_idx_r, bld_idx_nxt;
  logic                    wr_pend_r, wr_pend_nxt;
  logic [AW-1:0]           wr_addr_r, wr_addr_nxt;

  logic                    in_acc;
  logic                    out_load;
  logic [NW-1:0]           act_cnt;
  logic [NW-1:0]           span;
  logic                    lvl_ok;
  logic                    lvl_last;
  logic                    wr_idx_ok;
  qry_t                    q;

  logic                    ram_we;
  logic [AW-1:0]           ram_waddr;
  logic [VALUE_BITS-1:0]   ram_wdata;
  logic [AW-1:0]           ram_raddr_a;
  logic [AW-1:0]           ram_raddr_b;
  logic [VALUE_BITS-1:0]   rd_a;
  logic [VALUE_BITS-1:0]   rd_b;
  logic signed [VALUE_BITS-1:0] comb_val;

  assign in_if.ready   = (state_r == ST_IDLE) && (!out_valid_r || out_if.ready);
  assign in_acc        = in_if.valid && in_if.ready;
  assign out_if.valid  = out_valid_r;
  assign out_if.answer = out_answer_r;
  assign out_if.status = out_status_r;

  assign act_cnt   = (NW'(ent_cnt_r) > NW'(MAX_ENTRIES)) ? NW'(MAX_ENTRIES) : NW'(ent_cnt_r);
  assign span      = NW'(1) << bld_lvl_r;
  assign lvl_ok    = (bld_lvl_r != LCW'(LEVELS)) && (span <= act_cnt);
  assign lvl_last  = (NW'(bld_idx_r) + span) == act_cnt;
  assign wr_idx_ok = int'(in_if.element_index) < MAX_ENTRIES;

  strmm_qaddr #(
    .LEVELS (LEVELS),
    .NW     (NW)
  ) u_qaddr (
    .left_index  (in_if.left_index),
    .right_index (in_if.right_index),
    .act_cnt     (act_cnt),
    .q           (q)
  );

  strmm_ram #(
    .WIDTH (VALUE_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // signed min / max of the two read ports
  always_comb begin
    logic a_less;
    a_less = $signed(rd_a) < $signed(rd_b);
    if (sel_max_r) begin
      comb_val = a_less ? $signed(rd_b) : $signed(rd_a);
    end else begin
      comb_val = a_less ? $signed(rd_a) : $signed(rd_b);
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc && in_if.opcode == OP_BUILD) begin
          state_nxt = ST_BUILD;
        end else if (in_acc && in_if.opcode == OP_QUERY) begin
          state_nxt = ST_QUERY;
        end
      end
      ST_QUERY: state_nxt = ST_IDLE;
      ST_BUILD: begin
        if (!lvl_ok) begin
          state_nxt = ST_IDLE;
        end else if (lvl_last) begin
          state_nxt = ST_GAP;
        end
      end
      ST_GAP:   state_nxt = ST_BUILD;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    out_load       = 1'b0;
    out_answer_nxt = out_answer_r;
    out_status_nxt = out_status_r;
    q_err_nxt      = q_err_r;
    bld_lvl_nxt    = bld_lvl_r;
    bld_idx_nxt    = bld_idx_r;
    wr_pend_nxt    = 1'b0;
    wr_addr_nxt    = wr_addr_r;
    ram_we         = wr_pend_r;
    ram_waddr      = wr_addr_r;
    ram_wdata      = comb_val;
    ram_raddr_a    = {LW'(q.lvl), IW'(in_if.left_index)};
    ram_raddr_b    = {LW'(q.lvl), IW'(q.second)};

    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          unique case (in_if.opcode)
            OP_WRITE: begin
              ram_we         = wr_idx_ok;
              ram_waddr      = {LW'(0), IW'(in_if.element_index)};
              ram_wdata      = VALUE_BITS'(in_if.element_value);
              out_load       = 1'b1;
              out_answer_nxt = '0;
              out_status_nxt = !wr_idx_ok;
            end
            OP_BUILD: begin
              bld_lvl_nxt = LCW'(1);
              bld_idx_nxt = '0;
            end
            OP_QUERY: begin
              q_err_nxt = q.err;
            end
            default: begin
              out_load       = 1'b1;
              out_answer_nxt = '0;
              out_status_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_QUERY: begin
        out_load       = 1'b1;
        out_answer_nxt = q_err_r ? '0 : ANS_W'(comb_val);
        out_status_nxt = q_err_r;
      end
      ST_BUILD: begin
        ram_raddr_a = {LW'(bld_lvl_r - LCW'(1)), bld_idx_r};
        ram_raddr_b = {LW'(bld_lvl_r - LCW'(1)), bld_idx_r + IW'(span >> 1)};
        if (!lvl_ok) begin
          out_load       = 1'b1;
          out_answer_nxt = '0;
          out_status_nxt = 1'b0;
        end else begin
          wr_pend_nxt = 1'b1;
          wr_addr_nxt = {LW'(bld_lvl_r), bld_idx_r};
          if (lvl_last) begin
            bld_lvl_nxt = bld_lvl_r + LCW'(1);
            bld_idx_nxt = '0;
          end else begin
            bld_idx_nxt = bld_idx_r + IW'(1);
          end
        end
      end
      ST_GAP: begin
        // last write of the level lands here before the next level reads it
      end
      default: begin
      end
    endcase
  end

  assign out_valid_nxt = out_load || (out_valid_r && !out_if.ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      wr_pend_r   <= 1'b0;
      sel_max_r   <= 1'b0;
      ent_cnt_r   <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      wr_pend_r   <= wr_pend_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          REG_SELECT_MAX:  sel_max_r <= cfg_wdata[0];
          REG_ENTRY_COUNT: ent_cnt_r <= cfg_wdata;
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    out_answer_r <= out_answer_nxt;
    out_status_r <= out_status_nxt;
    q_err_r      <= q_err_nxt;
    bld_lvl_r    <= bld_lvl_nxt;
    bld_idx_r    <= bld_idx_nxt;
    wr_addr_r    <= wr_addr_nxt;
  end

endmodule

>>> rtl/strmm_chk.sv
module strmm_chk
  import strmm_pkg::*;
#(
  parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input op_t                     in_opcode,
  input logic [IDX_W-1:0]        in_element_index,
  input logic [IDX_W-1:0]        in_left_index,
  input logic [IDX_W-1:0]        in_right_index,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic signed [ANS_W-1:0] out_answer,
  input logic                    out_status
);

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  a_reset_clears: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken while result register blocked");

  a_write_done: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_opcode == OP_WRITE && int'(in_element_index) < MAX_ENTRIES
    |=> out_valid && !out_status && out_answer == '0)
    else $error("write result wrong");

  a_bad_order: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_opcode == OP_QUERY && in_left_index > in_right_index
    |-> ##2 out_valid && out_status && out_answer == '0)
    else $error("reversed range not flagged");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready
    |=> out_valid && $stable(out_answer) && $stable(out_status))
    else $error("stalled result changed");

endmodule

bind sparse_table_range_min_max_core strmm_chk #(
  .MAX_ENTRIES (MAX_ENTRIES)
) u_strmm_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_if.valid),
  .in_ready         (in_if.ready),
  .in_opcode        (in_if.opcode),
  .in_element_index (in_if.element_index),
  .in_left_index    (in_if.left_index),
  .in_right_index   (in_if.right_index),
  .out_valid        (out_if.valid),
  .out_ready        (out_if.ready),
  .out_answer       (out_if.answer),
  .out_status       (out_if.status)
);
